FILE: hdl/gtsc_pkg.sv
// Shared types, constants and the CORDIC arctangent table of the go-to-target
// speed command block. Used by every module of the block; depends on nothing.
`default_nettype none

package gtsc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int MAX_STAGES        = 24;

   // x and y carry the input scaled by 256; after the quarter turn and the
   // CORDIC gain they stay below 2^25 in magnitude.
   localparam int XW = 27;
   // Angle in units of 2^-24 rad, below 2^26 in magnitude.
   localparam int ZW = 28;
   // Bearing magnitude in mrad.
   localparam int MRAD_W = 12;

   localparam logic signed [ZW-1:0] HALF_PI_Z = 28'sd26353589;

   typedef enum logic [2:0] {
      REG_STOP_DISTANCE      = 3'd0,
      REG_LIN_SPEED_LIMIT    = 3'd1,
      REG_ANG_SPEED_LIMIT    = 3'd2,
      REG_LINEAR_GAIN        = 3'd3,
      REG_ANGULAR_GAIN       = 3'd4,
      REG_MISALIGN_THRESHOLD = 3'd5,
      REG_SLOW_FACTOR        = 3'd6
   } reg_index_type;

   localparam logic [15:0] STOP_DISTANCE_RST      = 16'd100;
   localparam logic [14:0] LIN_SPEED_LIMIT_RST    = 15'd150;
   localparam logic [14:0] ANG_SPEED_LIMIT_RST    = 15'd800;
   localparam logic [15:0] LINEAR_GAIN_RST        = 16'd205;
   localparam logic [15:0] ANGULAR_GAIN_RST       = 16'd512;
   localparam logic [11:0] MISALIGN_THRESHOLD_RST = 12'd300;
   localparam logic [7:0]  SLOW_FACTOR_RST        = 8'd77;

   typedef struct packed {
      logic [15:0] stop_distance;
      logic [14:0] lin_speed_limit;
      logic [14:0] ang_speed_limit;
      logic [15:0] linear_gain;
      logic [15:0] angular_gain;
      logic [11:0] misalign_threshold;
      logic [7:0]  slow_factor;
   } cfg_type;

   // Payload handed from cell to cell along the CORDIC chain.
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic [15:0]          range_mm;
      logic                 stopped;
      logic                 origin;
   } cordic_type;

   // atan(2^-i) in units of 2^-24 rad.
   function automatic logic signed [ZW-1:0] atan_entry(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:       val = 28'sd13176795;
         1:       val = 28'sd7778716;
         2:       val = 28'sd4110060;
         3:       val = 28'sd2086331;
         4:       val = 28'sd1047214;
         5:       val = 28'sd524117;
         6:       val = 28'sd262123;
         7:       val = 28'sd131069;
         8:       val = 28'sd65536;
         9:       val = 28'sd32768;
         10:      val = 28'sd16384;
         11:      val = 28'sd8192;
         12:      val = 28'sd4096;
         13:      val = 28'sd2048;
         14:      val = 28'sd1024;
         15:      val = 28'sd512;
         16:      val = 28'sd256;
         17:      val = 28'sd128;
         18:      val = 28'sd64;
         19:      val = 28'sd32;
         20:      val = 28'sd16;
         21:      val = 28'sd8;
         22:      val = 28'sd4;
         23:      val = 28'sd2;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/go_to_target_speed_command.sv
// Go-to-target speed command: registers, entry stage, chain of CORDIC cells
// and back end. Depends on gtsc_pkg, gtsc_pre, gtsc_cordic_cell, gtsc_post.
//
// A request beat carries the target offset and distance; every request gives
// exactly one response beat with the linear and angular speed commands and a
// stopped flag that is set when the stop distance rule forced both to zero.
// The bearing is found by a row of CORDIC_STAGES cells, one iteration each.
// The path from an accepted request to the response beat runs through one entry
// stage, one cell per iteration and three back-end stages, each registered.
// One request is taken in every cycle while the receiver does not stall.
// Every stage has its own valid bit, so when the receiver stalls the pipeline
// keeps filling its empty stages and req_tready drops only once all stages
// hold beats; a stalled response holds its data.
// The csr channel is always ready; a write of index 0 to 6 sets that register
// and other indexes are ignored. Registers should be written while no beat
// is in flight. Synchronous reset empties the pipeline and loads the default
// register values.

`default_nettype none

module go_to_target_speed_command
   import gtsc_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // target_x[15:0], target_y[31:16], target_distance[47:32]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // linear_speed[14:0], angular_speed[30:15], stopped[31]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   cfg_type cfg_ff;

   cordic_type stage_data  [CORDIC_STAGES+1];
   logic       stage_valid [CORDIC_STAGES+1];
   logic       stage_ready [CORDIC_STAGES+1];

   logic [14:0] linear_speed;
   logic [15:0] angular_speed;
   logic        stopped;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_distance      <= STOP_DISTANCE_RST;
         cfg_ff.lin_speed_limit    <= LIN_SPEED_LIMIT_RST;
         cfg_ff.ang_speed_limit    <= ANG_SPEED_LIMIT_RST;
         cfg_ff.linear_gain        <= LINEAR_GAIN_RST;
         cfg_ff.angular_gain       <= ANGULAR_GAIN_RST;
         cfg_ff.misalign_threshold <= MISALIGN_THRESHOLD_RST;
         cfg_ff.slow_factor        <= SLOW_FACTOR_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_STOP_DISTANCE:      cfg_ff.stop_distance      <= csr_data;
            REG_LIN_SPEED_LIMIT:    cfg_ff.lin_speed_limit    <= csr_data[14:0];
            REG_ANG_SPEED_LIMIT:    cfg_ff.ang_speed_limit    <= csr_data[14:0];
            REG_LINEAR_GAIN:        cfg_ff.linear_gain        <= csr_data;
            REG_ANGULAR_GAIN:       cfg_ff.angular_gain       <= csr_data;
            REG_MISALIGN_THRESHOLD: cfg_ff.misalign_threshold <= csr_data[11:0];
            REG_SLOW_FACTOR:        cfg_ff.slow_factor        <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   gtsc_pre u_pre (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (req_tvalid),
      .in_ready        (req_tready),
      .target_x        (req_tdata[15:0]),
      .target_y        (req_tdata[31:16]),
      .target_distance (req_tdata[47:32]),
      .out_valid       (stage_valid[0]),
      .out_ready       (stage_ready[0]),
      .out_data        (stage_data[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      gtsc_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stage_valid[i]),
         .in_ready  (stage_ready[i]),
         .in_data   (stage_data[i]),
         .out_valid (stage_valid[i+1]),
         .out_ready (stage_ready[i+1]),
         .out_data  (stage_data[i+1])
      );
   end

   gtsc_post u_post (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .in_valid      (stage_valid[CORDIC_STAGES]),
      .in_ready      (stage_ready[CORDIC_STAGES]),
      .in_data       (stage_data[CORDIC_STAGES]),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .linear_speed  (linear_speed),
      .angular_speed (angular_speed),
      .stopped       (stopped)
   );

   assign rsp_tdata = {stopped, angular_speed, linear_speed};

endmodule

`default_nettype wire

FILE: hdl/gtsc_pre.sv
// Entry stage: registers the request beat, applies the stop rule and turns
// targets behind the robot by a quarter turn. Depends on gtsc_pkg.
`default_nettype none

module gtsc_pre
   import gtsc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [15:0] target_x,
   input  wire logic [15:0] target_y,
   input  wire logic [15:0] target_distance,
   output logic             out_valid,
   input  wire logic        out_ready,
   output cordic_type       out_data
);

   logic       valid_ff;
   cordic_type data_ff;
   cordic_type data_in;

   logic signed [XW-1:0] xs;
   logic signed [XW-1:0] ys;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      xs = {{(XW-24){target_x[15]}}, target_x, 8'h00};
      ys = {{(XW-24){target_y[15]}}, target_y, 8'h00};
      data_in.range_mm = target_distance;
      data_in.stopped  = (target_distance == 16'd0) || (target_distance <= cfg.stop_distance);
      data_in.origin   = (target_x == 16'd0) && (target_y == 16'd0);
      data_in.x        = xs;
      data_in.y        = ys;
      data_in.z        = '0;
      if (xs < 0) begin
         if (ys >= 0) begin
            data_in.x = ys;
            data_in.y = -xs;
            data_in.z = HALF_PI_Z;
         end else begin
            data_in.x = -ys;
            data_in.y = xs;
            data_in.z = -HALF_PI_Z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gtsc_cordic_cell.sv
// One vectoring CORDIC iteration with its own pipeline register and handshake.
// Depends on gtsc_pkg for the payload type and the arctangent table.
`default_nettype none

module gtsc_cordic_cell
   import gtsc_pkg::*;
#(
   parameter int STAGE = 0
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire cordic_type in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output cordic_type      out_data
);

   localparam logic signed [ZW-1:0] ATAN_STEP = atan_entry(STAGE);

   logic       valid_ff;
   cordic_type data_ff;
   cordic_type data_in;

   logic signed [XW-1:0] dx;
   logic signed [XW-1:0] dy;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      dx      = in_data.y >>> STAGE;
      dy      = in_data.x >>> STAGE;
      data_in = in_data;
      // Rotate toward the x axis; y at zero counts as the lower half.
      if (in_data.y > 0) begin
         data_in.x = in_data.x + dx;
         data_in.y = in_data.y - dy;
         data_in.z = in_data.z + ATAN_STEP;
      end else begin
         data_in.x = in_data.x - dx;
         data_in.y = in_data.y + dy;
         data_in.z = in_data.z - ATAN_STEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gtsc_post.sv
// Three-stage back end: angle to mrad, gain products, rounding and clamps.
// The last stage is the response register. Depends on gtsc_pkg.
`default_nettype none

module gtsc_post
   import gtsc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire cfg_type    cfg,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire cordic_type in_data,
   output logic            out_valid,
   input  wire logic       out_ready,
   output logic [14:0]     linear_speed,
   output logic [15:0]     angular_speed,
   output logic            stopped
);

   // Stage 1: bearing magnitude in mrad and distance product.
   logic              v1_ff;
   logic              stop1_ff;
   logic              neg1_ff;
   logic [MRAD_W-1:0] mag1_ff;
   logic [31:0]       lp1_ff;
   // Stage 2: angular product, misalignment and slowed distance product.
   logic              v2_ff;
   logic              stop2_ff;
   logic              neg2_ff;
   logic [27:0]       wp2_ff;
   logic              mis2_ff;
   logic [31:0]       lp2_ff;
   logic [39:0]       lps2_ff;
   // Stage 3: response register.
   logic              v3_ff;
   logic [14:0]       lin3_ff;
   logic [15:0]       ang3_ff;
   logic              stop3_ff;

   logic r1;
   logic r2;
   logic r3;

   logic [ZW-2:0]     zabs;
   logic [36:0]       mrad_prod;
   logic [36:0]       mrad_round;
   logic [MRAD_W-1:0] mag1_in;
   logic              neg1_in;
   logic [31:0]       lp1_in;

   logic [27:0] wp2_in;
   logic [39:0] lps2_in;

   logic [28:0] w_round;
   logic [20:0] wmag;
   logic [14:0] wsat;
   logic [40:0] vs_round;
   logic [32:0] vn_round;
   logic [24:0] vfull;
   logic [14:0] lin3_in;
   logic [15:0] ang3_in;

   assign r3       = !v3_ff || out_ready;
   assign r2       = !v2_ff || r3;
   assign r1       = !v1_ff || r2;
   assign in_ready = r1;

   assign out_valid     = v3_ff;
   assign linear_speed  = lin3_ff;
   assign angular_speed = ang3_ff;
   assign stopped       = stop3_ff;

   always_comb begin
      zabs       = in_data.z[ZW-1] ? (ZW-1)'(-in_data.z) : in_data.z[ZW-2:0];
      mrad_prod  = 37'(zabs) * 37'(10'd1000);
      mrad_round = mrad_prod + 37'(24'h800000);
      mag1_in    = in_data.origin ? '0 : mrad_round[24+MRAD_W-1:24];
      neg1_in    = in_data.z[ZW-1] && !in_data.origin;
      lp1_in     = 32'(cfg.linear_gain) * 32'(in_data.range_mm);
   end

   always_comb begin
      wp2_in  = 28'(cfg.angular_gain) * 28'(mag1_ff);
      lps2_in = 40'(lp1_ff) * 40'(cfg.slow_factor);
   end

   always_comb begin
      w_round  = 29'(wp2_ff) + 29'd128;
      wmag     = w_round[28:8];
      wsat     = (wmag > 21'(cfg.ang_speed_limit)) ? cfg.ang_speed_limit : wmag[14:0];
      vs_round = 41'(lps2_ff) + 41'd32768;
      vn_round = 33'(lp2_ff) + 33'd128;
      vfull    = mis2_ff ? vs_round[40:16] : vn_round[32:8];
      lin3_in  = (vfull > 25'(cfg.lin_speed_limit)) ? cfg.lin_speed_limit : vfull[14:0];
      ang3_in  = neg2_ff ? -{1'b0, wsat} : {1'b0, wsat};
      if (stop2_ff) begin
         lin3_in = '0;
         ang3_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (r1) begin
            v1_ff <= in_valid;
         end
         if (r2) begin
            v2_ff <= v1_ff;
         end
         if (r3) begin
            v3_ff <= v2_ff;
         end
      end
      if (in_valid && r1) begin
         stop1_ff <= in_data.stopped;
         neg1_ff  <= neg1_in;
         mag1_ff  <= mag1_in;
         lp1_ff   <= lp1_in;
      end
      if (v1_ff && r2) begin
         stop2_ff <= stop1_ff;
         neg2_ff  <= neg1_ff;
         wp2_ff   <= wp2_in;
         mis2_ff  <= mag1_ff > cfg.misalign_threshold;
         lp2_ff   <= lp1_ff;
         lps2_ff  <= lps2_in;
      end
      if (v2_ff && r3) begin
         lin3_ff  <= lin3_in;
         ang3_ff  <= ang3_in;
         stop3_ff <= stop2_ff;
      end
   end

endmodule

`default_nettype wire

FILE: test/go_to_target_speed_command_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the go-to-target speed command block: follows the csr, req
// and rsp channels, predicts each response beat and compares it. Uses gtsc_pkg.

module go_to_target_speed_command_checker
   import gtsc_pkg::*;
#(
   parameter int STAGES = CORDIC_STAGES_DEF
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [47:0] req_tdata,   // target_x[15:0], target_y[31:16], target_distance[47:32]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // linear_speed[14:0], angular_speed[30:15], stopped[31]
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               pending
);

   typedef struct packed {
      logic [14:0]        linear;
      logic signed [15:0] angular;
      logic               stopped;
   } speed_cmd_type;

   // Quarter turn and atan(2^-i), both in units of 2^-24 rad.
   localparam longint QUARTER_TURN = 64'sd26353589;
   localparam longint ATAN_Z [0:MAX_STAGES-1] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   cfg_type       cfg;
   speed_cmd_type expected_cmds[$];

   // Bearing of the target in mrad, rounded half away from zero.
   function automatic longint target_bearing(input longint tx, input longint ty);
      longint px, py, ang, t, dx, dy, mag;
      int i;
      if (tx == 0 && ty == 0)
         return 0;
      px  = tx * 256;
      py  = ty * 256;
      ang = 0;
      // A target behind is first turned a quarter turn toward the front.
      if (px < 0) begin
         if (py >= 0) begin
            t = px; px = py; py = -t; ang = QUARTER_TURN;
         end else begin
            t = px; px = -py; py = t; ang = -QUARTER_TURN;
         end
      end
      for (i = 0; i < STAGES && i < MAX_STAGES; i++) begin
         dx = py >>> i;
         dy = px >>> i;
         if (py > 0) begin
            px += dx; py -= dy; ang += ATAN_Z[i];
         end else begin
            px -= dx; py += dy; ang -= ATAN_Z[i];
         end
      end
      mag = (ang < 0) ? -ang : ang;
      mag = (mag * 1000 + (64'sd1 <<< 23)) >>> 24;
      return (ang < 0) ? -mag : mag;
   endfunction

   function automatic speed_cmd_type speed_command(input logic [47:0] beat);
      speed_cmd_type cmd;
      longint tx, ty, bearing, w;
      longint unsigned range_mm, mag, wmag, v, lin_gain, ang_gain, slow;
      tx       = longint'($signed(beat[15:0]));
      ty       = longint'($signed(beat[31:16]));
      range_mm = 64'(beat[47:32]);
      lin_gain = 64'(cfg.linear_gain);
      ang_gain = 64'(cfg.angular_gain);
      slow     = 64'(cfg.slow_factor);
      cmd      = '0;
      if (range_mm == 0 || range_mm <= 64'(cfg.stop_distance)) begin
         cmd.stopped = 1'b1;
         return cmd;
      end
      bearing = target_bearing(tx, ty);
      mag     = (bearing < 0) ? -bearing : bearing;
      wmag    = (ang_gain * mag + 128) >> 8;
      if (wmag > 64'(cfg.ang_speed_limit))
         wmag = 64'(cfg.ang_speed_limit);
      w = (bearing < 0) ? -longint'(wmag) : longint'(wmag);
      // A misaligned robot drives slower; the slow factor joins the product
      // so that there is only one rounding.
      if (mag > 64'(cfg.misalign_threshold))
         v = (lin_gain * range_mm * slow + 32768) >> 16;
      else
         v = (lin_gain * range_mm + 128) >> 8;
      if (v > 64'(cfg.lin_speed_limit))
         v = 64'(cfg.lin_speed_limit);
      cmd.linear  = v[14:0];
      cmd.angular = w[15:0];
      return cmd;
   endfunction

   always @(posedge clock) begin : watch
      speed_cmd_type got, want;
      int errs;
      errs = 0;
      if (reset) begin
         cfg.stop_distance      <= STOP_DISTANCE_RST;
         cfg.lin_speed_limit    <= LIN_SPEED_LIMIT_RST;
         cfg.ang_speed_limit    <= ANG_SPEED_LIMIT_RST;
         cfg.linear_gain        <= LINEAR_GAIN_RST;
         cfg.angular_gain       <= ANGULAR_GAIN_RST;
         cfg.misalign_threshold <= MISALIGN_THRESHOLD_RST;
         cfg.slow_factor        <= SLOW_FACTOR_RST;
         expected_cmds.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_STOP_DISTANCE:      cfg.stop_distance      <= csr_data;
               REG_LIN_SPEED_LIMIT:    cfg.lin_speed_limit    <= csr_data[14:0];
               REG_ANG_SPEED_LIMIT:    cfg.ang_speed_limit    <= csr_data[14:0];
               REG_LINEAR_GAIN:        cfg.linear_gain        <= csr_data;
               REG_ANGULAR_GAIN:       cfg.angular_gain       <= csr_data;
               REG_MISALIGN_THRESHOLD: cfg.misalign_threshold <= csr_data[11:0];
               REG_SLOW_FACTOR:        cfg.slow_factor        <= csr_data[7:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.linear  = rsp_tdata[14:0];
            got.angular = rsp_tdata[30:15];
            got.stopped = rsp_tdata[31];
            if (expected_cmds.size() == 0) begin
               $error("rsp beat with no request outstanding: %h", rsp_tdata);
               errs++;
            end else begin
               want = expected_cmds.pop_front();
               if (got.linear !== want.linear) begin
                  $error("linear_speed: expected %0d, got %0d", want.linear, got.linear);
                  errs++;
               end
               if (got.angular !== want.angular) begin
                  $error("angular_speed: expected %0d, got %0d", want.angular, got.angular);
                  errs++;
               end
               if (got.stopped !== want.stopped) begin
                  $error("stopped: expected %0d, got %0d", want.stopped, got.stopped);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_cmds.push_back(speed_command(req_tdata));
      end
      fail_count <= fail_count + errs;
      pending    <= expected_cmds.size();
   end

endmodule

FILE: test/go_to_target_speed_command_tb.sv
`timescale 1ns / 1ps
// Top of the go-to-target speed command testbench: clock, reset, register
// settings and target beats. Depends on gtsc_pkg, the block and its checker.

module go_to_target_speed_command_tb
   import gtsc_pkg::*;
();

   localparam int STAGES       = CORDIC_STAGES_DEF;
   localparam int SETTLE       = STAGES + 20;
   localparam int SEGMENTS     = 6;
   localparam int SEG_ITEMS [0:SEGMENTS-1] = '{250, 250, 150, 250, 50, 250};
   localparam logic [2:0] UNUSED_CSR_INDEX = 3'd7;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [47:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   int          fail_count;
   int          pending;

   int send_idle;
   int recv_idle;
   int stop_mm;
   int thr_mrad;

   go_to_target_speed_command #(.CORDIC_STAGES(STAGES)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   go_to_target_speed_command_checker #(.STAGES(STAGES)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle);

   initial begin
      #2000000;
      $display("go_to_target_speed_command_tb: FAIL");
      $finish;
   end

   // All driving tasks start and end just after a falling edge.
   task automatic send_target(input logic [15:0] tx, input logic [15:0] ty,
                              input logic [15:0] range_mm);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {range_mm, ty, tx};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after its last beat.
   task automatic csr_beat(input logic [2:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (pending != 0);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic apply_config(input int seg);
      logic [15:0] stop, max_lin, max_ang, lin_gain, ang_gain, thr, slow;
      case (seg)
         1: begin
            // Stop and threshold zero, the rest at its top; upper bits dropped.
            stop = 16'd0;     max_lin = 16'hFFFF; max_ang = 16'hFFFF;
            lin_gain = 16'hFFFF; ang_gain = 16'hFFFF; thr = 16'd0; slow = 16'hFFFF;
         end
         2: begin
            stop = 16'd1;     max_lin = 16'h8000; max_ang = 16'h8000;
            lin_gain = 16'hFFFF; ang_gain = 16'hFFFF; thr = 16'd3142; slow = 16'h0100;
         end
         4: begin
            // Nothing gets past the stop rule here.
            stop = 16'hFFFF;  max_lin = 16'd0; max_ang = 16'd0;
            lin_gain = 16'd0; ang_gain = 16'd0; thr = 16'hF000; slow = 16'd0;
         end
         default: begin
            stop     = 16'($urandom_range(0, 3000));
            max_lin  = 16'($urandom);
            max_ang  = 16'($urandom);
            lin_gain = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1024));
            ang_gain = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1024));
            thr      = 16'($urandom_range(0, 3142));
            slow     = 16'($urandom);
         end
      endcase
      csr_beat(REG_STOP_DISTANCE, stop);
      csr_beat(REG_LIN_SPEED_LIMIT, max_lin);
      csr_beat(REG_ANG_SPEED_LIMIT, max_ang);
      csr_beat(REG_LINEAR_GAIN, lin_gain);
      csr_beat(REG_ANGULAR_GAIN, ang_gain);
      csr_beat(REG_MISALIGN_THRESHOLD, thr);
      csr_beat(REG_SLOW_FACTOR, slow);
      if (seg == 2)
         csr_beat(UNUSED_CSR_INDEX, 16'hFFFF);
      csr_valid <= 1'b0;
      stop_mm  = int'(stop);
      thr_mrad = int'(thr[11:0]);
   endtask

   task automatic random_target();
      int tx, ty, range_mm;
      case ($urandom_range(0, 5))
         0, 1: begin
            tx = $urandom_range(0, 65535) - 32768;
            ty = $urandom_range(0, 65535) - 32768;
         end
         2: begin
            tx = $urandom_range(0, 64) - 32;
            ty = $urandom_range(0, 64) - 32;
         end
         3: begin
            // Behind the robot, close to the rear axis.
            tx = -$urandom_range(1, 32768);
            ty = $urandom_range(0, 4) - 2;
         end
         4: begin
            tx = $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535) - 32768;
            ty = (tx != 0) ? 0 : $urandom_range(0, 65535) - 32768;
         end
         default: begin
            // Bearing near the misalignment threshold.
            tx = $urandom_range(1000, 30000);
            ty = tx * thr_mrad / 1000 + $urandom_range(0, 20) - 10;
            if (ty > 32767)
               ty = 32767;
            if ($urandom_range(0, 1))
               ty = -ty;
         end
      endcase
      case ($urandom_range(0, 7))
         0:       range_mm = $urandom_range(0, 65535);
         1:       range_mm = stop_mm + $urandom_range(0, 2) - 1;
         2:       range_mm = $urandom_range(0, 1) ? 65535 : 0;
         default: range_mm = stop_mm + $urandom_range(1, 3000);
      endcase
      if (range_mm < 0)
         range_mm = 0;
      if (range_mm > 65535)
         range_mm = 65535;
      send_target(tx[15:0], ty[15:0], range_mm[15:0]);
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_data   = '0;
      send_idle  = 26;
      recv_idle  = 58;
      stop_mm    = int'(STOP_DISTANCE_RST);
      thr_mrad   = int'(MISALIGN_THRESHOLD_RST);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg > 0) begin
            drain_pipeline();
            apply_config(seg);
         end
         send_idle = (seg < 2) ? 26 : (seg < 4) ? 58 : 0;
         recv_idle = (seg < 2) ? 58 : (seg < 4) ? 26 : 0;
         if (seg == 0) begin
            send_target(16'd0, 16'd0, 16'd1000);          // origin
            send_target(-16'sd100, 16'd0, 16'd1000);      // straight behind
            send_target(-16'sd100, 16'd50, 16'd1000);
            send_target(-16'sd100, -16'sd50, 16'd1000);
            send_target(16'h7FFF, 16'h7FFF, 16'hFFFF);
            send_target(16'h8000, 16'h8000, 16'hFFFF);
            send_target(16'h8000, 16'h7FFF, 16'd5000);
            send_target(16'h7FFF, 16'h8000, 16'd5000);
            send_target(16'd0, 16'h7FFF, 16'd5000);
            send_target(16'd0, 16'h8000, 16'd5000);
            send_target(16'h8000, 16'd0, 16'd5000);
            send_target(16'd500, 16'd0, 16'd0);           // no target
            send_target(16'd500, 16'd0, 16'd100);         // at the stop distance
            send_target(16'd500, 16'd0, 16'd101);
            send_target(16'd1000, 16'd350, 16'd2000);     // misaligned
            send_target(16'd1000, 16'd290, 16'd2000);
            send_target(16'd1000, -16'sd350, 16'd2000);
            send_target(16'hFFFF, 16'd0, 16'd200);
            send_target(16'd0, 16'hFFFF, 16'd200);
            send_target(16'd1, 16'd1, 16'd300);
         end
         for (int n = 0; n < SEG_ITEMS[seg]; n++) begin
            if (seg == 0 && n == 120)
               drain_pipeline();
            random_target();
         end
      end
      drain_pipeline();

      if (fail_count == 0)
         $display("go_to_target_speed_command_tb: PASS");
      else
         $display("go_to_target_speed_command_tb: FAIL");
      $finish;
   end

endmodule

FILE: go_to_target_speed_command.f
hdl/gtsc_pkg.sv
hdl/gtsc_pre.sv
hdl/gtsc_cordic_cell.sv
hdl/gtsc_post.sv
hdl/go_to_target_speed_command.sv
test/go_to_target_speed_command_checker.sv
test/go_to_target_speed_command_tb.sv
